FILE: hdl/htwd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder package
// Shared widths, codes and types for the tree-walk decoder and its output
// stage.
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int IDX_W          = 7;
    localparam int SYM_W          = 8;
    localparam int CODE_W         = 8;
    localparam int CNT_W          = $clog2(CODE_W + 1);
    localparam int NODE_COUNT_DEF = 128;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // One entry of the node table.
    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } node_t;

    // Events from the walk engine to the output stage.
    typedef struct packed {
        logic             hit;   // a leaf was reached, sym is its symbol
        logic             done;  // the code byte is used up
        logic [SYM_W-1:0] sym;
    } walk_ev_t;

endpackage

`default_nettype wire

FILE: hdl/huffman_tree_walk_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder
// Bit-serial decoder that walks a Huffman tree held in a node table memory,
// one code bit per cycle unless stalled, and emits a symbol at each leaf reached.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Word
//  s_*       in         s_valid / s_ready    load node or one code byte
//  m_*       out        m_valid / m_ready    one decoded symbol, last flag
//  cfg_*     in         cfg_wr_en            root node index, no read-back
//
// A load word is written at the edge that takes it and the input stays ready,
// so loads can follow one per cycle. A code byte keeps the input busy while
// the walk reads the first child, then tests each child for a leaf (all but
// the last also reading the next child) until the eight code bits are used up,
// and then releases the last symbol before the next word is taken. After
// reset or a load word a fetch of the current node comes first, and the first
// leaf reached after a change of root costs a fetch to bring the new root
// node into its cache. A full result register stalls the walk for as long as
// a further symbol must move on. Reset clears the control state; the table
// holds garbage until written.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
    parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input words
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_mode,
    input  wire logic [htwd_pkg::IDX_W-1:0] s_node_index,
    input  wire logic [htwd_pkg::IDX_W-1:0] s_left_child,
    input  wire logic [htwd_pkg::IDX_W-1:0] s_right_child,
    input  wire logic                      s_leaf_flag,
    input  wire logic [htwd_pkg::SYM_W-1:0] s_leaf_symbol,
    input  wire logic [htwd_pkg::CODE_W-1:0] s_code_byte,
    // result words
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [htwd_pkg::SYM_W-1:0]     m_symbol,
    output logic                           m_last,
    // root node register
    input  wire logic                      cfg_wr_en,
    input  wire logic [htwd_pkg::IDX_W-1:0] cfg_wr_data
);

    localparam int AW = $clog2(NODE_COUNT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // Node table with a registered read port.
    htwd_pkg::node_t node_mem [NODE_COUNT];
    htwd_pkg::node_t mem_q;

    // Control state.
    logic [1:0]                  state_reg,     state_next;
    logic                        rd_phase_reg,  rd_phase_next;
    logic                        cur_ok_reg,    cur_ok_next;
    logic                        root_ok_reg,   root_ok_next;
    logic [htwd_pkg::IDX_W-1:0]  root_reg;
    logic [htwd_pkg::IDX_W-1:0]  pos_reg,       pos_next;
    logic [htwd_pkg::CNT_W-1:0]  bits_left_reg, bits_left_next;

    // Walk data.
    htwd_pkg::node_t             cur_reg,       cur_next;
    htwd_pkg::node_t             root_data_reg, root_data_next;
    logic [htwd_pkg::CODE_W-1:0] code_reg,      code_next;
    logic [htwd_pkg::IDX_W-1:0]  addr_reg,      addr_next;
    logic                        rd_oob_reg;

    logic [htwd_pkg::IDX_W-1:0]  rd_addr;
    logic                        rd_oob;
    htwd_pkg::node_t             rd_node;
    htwd_pkg::node_t             node_now;
    htwd_pkg::node_t             wr_node;
    logic                        s_accept;
    logic                        wr_en;
    logic                        leaf_hit;
    logic                        stall;
    htwd_pkg::walk_ev_t          ev;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    // Entries beyond the table are ignored on a load but still reset the walk.
    assign wr_en    = s_accept && (s_mode == htwd_pkg::MODE_LOAD)
                      && (32'(s_node_index) < NODE_COUNT);

    assign wr_node.left  = s_left_child;
    assign wr_node.right = s_right_child;
    assign wr_node.leaf  = s_leaf_flag;
    assign wr_node.sym   = s_leaf_symbol;

    // A node outside the table reads as an inner node with both children at 0.
    assign rd_oob  = (32'(rd_addr) >= NODE_COUNT);
    assign rd_node = rd_oob_reg ? '0 : mem_q;

    // A leaf is only ever tested on a child that was just read.
    assign leaf_hit = (state_reg == ST_RUN) && rd_phase_reg && rd_node.leaf;

    assign ev.hit  = leaf_hit;
    assign ev.done = (state_reg == ST_FLUSH);
    assign ev.sym  = rd_node.sym;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[AW'(s_node_index)] <= wr_node;
        end
        mem_q <= node_mem[AW'(rd_addr)];
    end

    always_comb begin
        state_next     = state_reg;
        rd_phase_next  = rd_phase_reg;
        cur_ok_next    = cur_ok_reg;
        root_ok_next   = root_ok_reg;
        pos_next       = pos_reg;
        bits_left_next = bits_left_reg;
        cur_next       = cur_reg;
        root_data_next = root_data_reg;
        code_next      = code_reg;
        addr_next      = addr_reg;
        rd_addr        = pos_reg;
        // Once a leaf is reached, the walk goes on from the cached root node.
        node_now       = cur_reg;
        if (rd_phase_reg) begin
            node_now = rd_node.leaf ? root_data_reg : rd_node;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_mode == htwd_pkg::MODE_LOAD) begin
                        pos_next     = root_reg;
                        cur_ok_next  = 1'b0;
                        root_ok_next = 1'b0;
                    end else begin
                        code_next      = s_code_byte;
                        bits_left_next = htwd_pkg::CNT_W'(htwd_pkg::CODE_W);
                        rd_phase_next  = 1'b0;
                        // The read of pos_reg issued now serves the fetch.
                        state_next     = cur_ok_reg ? ST_RUN : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cur_next    = rd_node;
                cur_ok_next = 1'b1;
                if (pos_reg == root_reg) begin
                    root_data_next = rd_node;
                    root_ok_next   = 1'b1;
                end
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (stall) begin
                    // Re-read the same entry so the read data stays put.
                    rd_addr = addr_reg;
                end else begin
                    if (leaf_hit) begin
                        pos_next = root_reg;
                    end
                    if (leaf_hit && !root_ok_reg) begin
                        rd_addr       = root_reg;
                        pos_next      = root_reg;
                        cur_ok_next   = 1'b0;
                        rd_phase_next = 1'b0;
                        state_next    = ST_FETCH;
                    end else begin
                        cur_next = node_now;
                        if (bits_left_reg != '0) begin
                            rd_addr        = code_reg[htwd_pkg::CODE_W-1] ? node_now.right
                                                                         : node_now.left;
                            addr_next      = rd_addr;
                            rd_phase_next  = 1'b1;
                            code_next      = code_reg << 1;
                            bits_left_next = bits_left_reg - htwd_pkg::CNT_W'(1);
                        end else begin
                            rd_phase_next = 1'b0;
                            state_next    = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new root invalidates the cached root node; the walk stays put.
        if (cfg_wr_en) begin
            root_ok_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_phase_reg  <= 1'b0;
            cur_ok_reg    <= 1'b0;
            root_ok_reg   <= 1'b0;
            root_reg      <= '0;
            pos_reg       <= '0;
            bits_left_reg <= '0;
        end else begin
            state_reg     <= state_next;
            rd_phase_reg  <= rd_phase_next;
            cur_ok_reg    <= cur_ok_next;
            root_ok_reg   <= root_ok_next;
            pos_reg       <= pos_next;
            bits_left_reg <= bits_left_next;
            if (cfg_wr_en) begin
                root_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        root_data_reg <= root_data_next;
        code_reg      <= code_next;
        addr_reg      <= addr_next;
        rd_oob_reg    <= rd_oob;
    end

    htwd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev       (ev),
        .stall    (stall),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_symbol (m_symbol),
        .m_last   (m_last)
    );

endmodule

`default_nettype wire

FILE: hdl/htwd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman decoder output stage
// Holds the newest symbol back until the next one arrives or the code byte
// ends, so that the last flag is known, and drives the result register.
// ----------------------------------------------------------------------------
module htwd_out_stage (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire htwd_pkg::walk_ev_t       ev,
    output logic                          stall,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [htwd_pkg::SYM_W-1:0]    m_symbol,
    output logic                          m_last
);

    logic                      pend_valid_reg;
    logic [htwd_pkg::SYM_W-1:0] pend_sym_reg;
    logic                      m_valid_reg;
    logic [htwd_pkg::SYM_W-1:0] m_symbol_reg;
    logic                      m_last_reg;
    logic                      out_free;
    logic                      push_out;
    logic                      push_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign stall     = (ev.hit || ev.done) && pend_valid_reg && !out_free;
    // A held symbol leaves when a newer one arrives, or as the last of its byte.
    assign push_out  = !stall && pend_valid_reg && (ev.hit || ev.done);
    assign push_last = !ev.hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (push_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (!stall) begin
                if (ev.hit) begin
                    pend_valid_reg <= 1'b1;
                end else if (ev.done) begin
                    pend_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_out) begin
            m_symbol_reg <= pend_sym_reg;
            m_last_reg   <= push_last;
        end
        if (!stall && ev.hit) begin
            pend_sym_reg <= ev.sym;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;

endmodule

`default_nettype wire

FILE: test/tb_huffman_tree_walk_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Huffman tree-walk decoder
// Loads decoding trees into the node table, changes the root between phases
// and streams code bytes through the block. Both channels idle and stall at
// random. A predictor in the testbench keeps its own node table and walk
// position and checks every symbol word, in order, against its expectation.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder;

    localparam int   IDX_W          = htwd_pkg::IDX_W;
    localparam int   SYM_W          = htwd_pkg::SYM_W;
    localparam int   CODE_W         = htwd_pkg::CODE_W;
    localparam int   NODE_COUNT_DEF = htwd_pkg::NODE_COUNT_DEF;
    localparam logic MODE_LOAD      = htwd_pkg::MODE_LOAD;
    localparam logic MODE_DECODE    = htwd_pkg::MODE_DECODE;

    typedef htwd_pkg::node_t node_t;

    localparam int RANDOM_WORDS = 430;
    localparam int IDLE_CYCLES  = 24;    // covers the walk of a byte that yields no symbol
    localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving before giving up
    localparam int MAX_LEAVES   = 12;
    localparam int MAX_TREE     = 2 * MAX_LEAVES - 1;
    localparam int MAX_MISMATCH_REPORTS = 10;

    // One input word, exactly as it is presented on the s_ channel.
    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  node_index;
        logic [IDX_W-1:0]  left_child;
        logic [IDX_W-1:0]  right_child;
        logic              leaf_flag;
        logic [SYM_W-1:0]  leaf_symbol;
        logic [CODE_W-1:0] code_byte;
    } in_word_t;

    // One result word on the m_ channel.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } sym_word_t;

    // The scoreboard keeps a private copy of the node table, the walk position
    // and the root register. Accepted input words update that copy; decode
    // words append the symbols they produce to the queue of expected words.
    class htwd_symbol_board;
        node_t            node_tbl[NODE_COUNT_DEF];
        bit               written[NODE_COUNT_DEF];
        logic [IDX_W-1:0] walk_pos;
        logic [IDX_W-1:0] root_idx;
        sym_word_t        expected_syms[$];
        int               failures;

        function new();
            foreach (node_tbl[i]) begin
                node_tbl[i] = '0;
                written[i]  = 1'b0;
            end
            walk_pos = '0;
            root_idx = '0;
            failures = 0;
        endfunction

        function void set_root(logic [IDX_W-1:0] idx);
            root_idx = idx;
        endfunction

        function int pending();
            return expected_syms.size();
        endfunction

        // Walks one code byte from the current position. It returns whether
        // every table entry read on the way has been written. With commit set
        // the walk position moves and the symbols found become expectations.
        function bit trace_walk(logic [CODE_W-1:0] code, bit commit);
            logic [IDX_W-1:0] pos;
            node_t            cur;
            sym_word_t        found[$];
            bit               safe;
            pos  = walk_pos;
            safe = 1'b1;
            for (int b = CODE_W - 1; b >= 0; b--) begin
                safe = safe & written[pos];
                cur  = node_tbl[pos];
                pos  = code[b] ? cur.right : cur.left;
                safe = safe & written[pos];
                if (node_tbl[pos].leaf) begin
                    found.push_back('{sym: node_tbl[pos].sym, last: 1'b0});
                    pos = root_idx;
                end
            end
            if (commit) begin
                if (found.size() > 0) found[found.size() - 1].last = 1'b1;
                foreach (found[i]) expected_syms.push_back(found[i]);
                walk_pos = pos;
            end
            return safe;
        endfunction

        function void note_word(in_word_t w);
            if (w.mode == MODE_LOAD) begin
                node_tbl[w.node_index] = '{left: w.left_child, right: w.right_child,
                                           leaf: w.leaf_flag, sym: w.leaf_symbol};
                written[w.node_index]  = 1'b1;
                walk_pos = root_idx;
            end else begin
                void'(trace_walk(w.code_byte, 1'b1));
            end
        endfunction

        function void check_symbol(logic [SYM_W-1:0] sym, logic last);
            sym_word_t want;
            string     msg;
            msg = "";
            if (expected_syms.size() == 0) begin
                msg = $sformatf("symbol word %02h last %0b arrived with none expected",
                                sym, last);
            end else begin
                want = expected_syms.pop_front();
                if (sym !== want.sym || last !== want.last)
                    msg = $sformatf("expected symbol %02h last %0b, got symbol %02h last %0b",
                                    want.sym, want.last, sym, last);
            end
            if (msg != "") begin
                failures++;
                if (failures <= MAX_MISMATCH_REPORTS) $display("%0t: %s", $time, msg);
            end
        endfunction
    endclass

    // Clock and reset. Reset is held low from time zero and released once.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #2 aclk = ~aclk;

    // Every input of the block starts at a known value.
    logic              s_valid       = 1'b0;
    logic              s_mode        = MODE_LOAD;
    logic [IDX_W-1:0]  s_node_index  = '0;
    logic [IDX_W-1:0]  s_left_child  = '0;
    logic [IDX_W-1:0]  s_right_child = '0;
    logic              s_leaf_flag   = 1'b0;
    logic [SYM_W-1:0]  s_leaf_symbol = '0;
    logic [CODE_W-1:0] s_code_byte   = '0;
    logic              m_ready       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]  cfg_wr_data   = '0;
    wire               s_ready;
    wire               m_valid;
    wire [SYM_W-1:0]   m_symbol;
    wire               m_last;

    htwd_symbol_board board;
    int  words_taken  = 0;
    int  quiet_cycles = 0;
    int  stall_left   = 0;
    bit  calm         = 1'b0;   // when set, neither side idles nor stalls

    // The tree of the current phase: slot 0 is its root.
    logic [IDX_W-1:0] tree_at[MAX_TREE];
    logic [IDX_W-1:0] tree_left[MAX_TREE];
    logic [IDX_W-1:0] tree_right[MAX_TREE];
    logic             tree_leaf[MAX_TREE];
    logic [SYM_W-1:0] tree_sym[MAX_TREE];
    int               tree_size = 0;

    huffman_tree_walk_decoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_node_index  (s_node_index),
        .s_left_child  (s_left_child),
        .s_right_child (s_right_child),
        .s_leaf_flag   (s_leaf_flag),
        .s_leaf_symbol (s_leaf_symbol),
        .s_code_byte   (s_code_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Length of an idle stretch: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // A word with every field random; callers overwrite the fields that matter,
    // so the fields that the mode ignores still carry arbitrary values.
    function automatic in_word_t junk_word();
        in_word_t w;
        w.mode        = 1'($urandom_range(0, 1));
        w.node_index  = IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1));
        w.left_child  = IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1));
        w.right_child = IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1));
        w.leaf_flag   = 1'($urandom_range(0, 1));
        w.leaf_symbol = SYM_W'($urandom_range(0, 255));
        w.code_byte   = CODE_W'($urandom_range(0, 255));
        return w;
    endfunction

    // Presents one word after a random gap and holds it until it is taken.
    // The predictor is updated at the very edge that takes the word, so the
    // caller always sees the state that the next word will meet.
    task automatic send_word(in_word_t w);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_mode        = w.mode;
        s_node_index  = w.node_index;
        s_left_child  = w.left_child;
        s_right_child = w.right_child;
        s_leaf_flag   = w.leaf_flag;
        s_leaf_symbol = w.leaf_symbol;
        s_code_byte   = w.code_byte;
        do @(posedge aclk); while (!s_ready);
        board.note_word(w);
        words_taken++;
    endtask

    task automatic load_node(logic [IDX_W-1:0] idx, logic [IDX_W-1:0] left,
                             logic [IDX_W-1:0] right, logic leaf, logic [SYM_W-1:0] sym);
        in_word_t w;
        w             = junk_word();
        w.mode        = MODE_LOAD;
        w.node_index  = idx;
        w.left_child  = left;
        w.right_child = right;
        w.leaf_flag   = leaf;
        w.leaf_symbol = sym;
        send_word(w);
    endtask

    task automatic decode_code(logic [CODE_W-1:0] code);
        in_word_t w;
        w           = junk_word();
        w.mode      = MODE_DECODE;
        w.code_byte = code;
        send_word(w);
    endtask

    task automatic load_tree_slot(int k);
        load_node(tree_at[k], tree_left[k], tree_right[k], tree_leaf[k], tree_sym[k]);
    endtask

    // Writes the whole tree of the current phase again, which also sends the
    // walk back to the root.
    task automatic reload_tree();
        for (int k = 0; k < tree_size; k++) load_tree_slot(k);
    endtask

    // Drops valid, lets every expected word arrive, then allows the engine
    // time to finish a byte that may still be walking without a symbol.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    // The root register is written only once the block has gone quiet.
    task automatic set_root(logic [IDX_W-1:0] idx);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = idx;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.set_root(idx);
    endtask

    // Result side: ready drops for random stretches, driven at the falling edge.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            m_ready    = (stall_left == 0);
        end
    end

    // Every symbol word taken at a rising edge is checked against the oldest
    // expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_symbol(m_symbol, m_last);
    end

    // Watchdog: the run is abandoned when no word moves on either channel for
    // far longer than the slowest legitimate stretch of idling and stalling.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int               start_count;
        int               phase;
        int               root_at;
        int               n;
        int               leaves;
        int               k;
        int               j;
        int               t;
        int               r;
        int               tries;
        int               perm[NODE_COUNT_DEF];
        int               kid_l[MAX_TREE];
        int               kid_r[MAX_TREE];
        bit               is_leaf[MAX_TREE];
        bit               found_safe;
        logic [CODE_W-1:0] code;
        in_word_t         w;

        board = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. A small tree at root 0: node 1 is a leaf for the
        // code 0, node 3 for 10 and node 127 for 11. Node 127 also carries
        // children so that it can serve as a root that is itself a leaf, and
        // node 4 loops on itself so that a byte can yield no symbol at all.
        load_node(7'd0, 7'd1, 7'd2, 1'b0, 8'h3C);
        load_node(7'd1, 7'd127, 7'd0, 1'b1, 8'h00);
        load_node(7'd2, 7'd3, 7'd127, 1'b0, 8'hC3);
        load_node(7'd3, 7'd0, 7'd127, 1'b1, 8'hFF);
        load_node(7'd127, 7'd1, 7'd3, 1'b1, 8'hA5);
        load_node(7'd4, 7'd4, 7'd4, 1'b0, 8'h5A);
        set_root(7'd0);
        decode_code(8'h00);   // eight symbols from one byte
        decode_code(8'hFF);
        decode_code(8'hAA);
        decode_code(8'h01);   // ends part way down the tree
        decode_code(8'h7F);   // finishes the code left open by the byte before
        load_node(7'd1, 7'd127, 7'd0, 1'b1, 8'h00);   // a load in mid code restarts the walk
        decode_code(8'h80);
        // A new root does not move the walk; it only takes effect when the walk next returns to the root.
        // Root 127 is a leaf, but standing as the root it is never emitted itself.
        set_root(7'd127);
        decode_code(8'hC0);
        decode_code(8'h55);
        // Root 4 traps the walk, so the second byte yields nothing.
        set_root(7'd4);
        decode_code(8'h00);
        decode_code(8'hFF);
        set_root(7'd0);
        load_node(7'd4, 7'd4, 7'd4, 1'b0, 8'h5A);
        decode_code(8'hB6);

        // Random part: each phase loads a fresh full binary tree at random
        // table entries, points the root register at it and then streams
        // code bytes mixed with stray loads and rewrites of tree nodes.
        start_count = words_taken;
        phase       = 0;
        while (words_taken - start_count < RANDOM_WORDS) begin
            calm    = ($urandom_range(0, 3) == 0);
            root_at = (phase == 0) ? NODE_COUNT_DEF - 1 :
                      (phase == 1) ? 0 : $urandom_range(0, NODE_COUNT_DEF - 1);

            // Pick distinct table entries, with the root's own entry first.
            foreach (perm[i]) perm[i] = i;
            perm[0]       = root_at;
            perm[root_at] = 0;
            for (int i = NODE_COUNT_DEF - 1; i > 1; i--) begin
                j       = $urandom_range(1, i);
                t       = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end

            // Grow the tree shape by splitting random leaves.
            n          = 1;
            leaves     = 1;
            is_leaf[0] = 1'b1;
            while (leaves < $urandom_range(2, MAX_LEAVES)) begin
                k = $urandom_range(0, n - 1);
                if (is_leaf[k]) begin
                    kid_l[k]       = n;
                    kid_r[k]       = n + 1;
                    is_leaf[k]     = 1'b0;
                    is_leaf[n]     = 1'b1;
                    is_leaf[n + 1] = 1'b1;
                    n              = n + 2;
                    leaves++;
                end
            end
            tree_size = n;
            for (int i = 0; i < n; i++) begin
                tree_at[i]    = IDX_W'(perm[i]);
                tree_leaf[i]  = is_leaf[i];
                tree_sym[i]   = SYM_W'($urandom_range(0, 255));
                // The children of a leaf are never followed, so they are random.
                tree_left[i]  = is_leaf[i] ? IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1))
                                           : IDX_W'(perm[kid_l[i]]);
                tree_right[i] = is_leaf[i] ? IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1))
                                           : IDX_W'(perm[kid_r[i]]);
            end
            reload_tree();
            set_root(IDX_W'(root_at));
            load_tree_slot(0);   // brings the walk to the new root

            repeat ($urandom_range(15, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    // A stray load; its children mostly point into the tree.
                    w      = junk_word();
                    w.mode = MODE_LOAD;
                    if ($urandom_range(0, 9) < 7) begin
                        w.left_child  = tree_at[$urandom_range(0, tree_size - 1)];
                        w.right_child = tree_at[$urandom_range(0, tree_size - 1)];
                    end
                    send_word(w);
                end else if (r < 12) begin
                    load_tree_slot($urandom_range(0, tree_size - 1));
                end else begin
                    // Only bytes whose walk stays on written entries are sent;
                    // if stray loads have cut the tree, it is written again.
                    found_safe = 1'b0;
                    for (tries = 0; tries < 16 && !found_safe; tries++) begin
                        code       = CODE_W'($urandom_range(0, 255));
                        found_safe = board.trace_walk(code, 1'b0);
                    end
                    if (found_safe) begin
                        decode_code(code);
                    end else begin
                        reload_tree();
                    end
                end
            end
            phase++;
        end

        calm = 1'b0;
        wait_idle();
        if (board.failures == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
